// ----- rtl/m2a_pkg.sv -----
package m2a_pkg;

    localparam logic [31:0] C_M       = 32'h5bd1e995;
    localparam int          C_R       = 24;
    localparam int          C_FIN_SH1 = 13;
    localparam int          C_FIN_SH2 = 15;
    localparam logic [2:0]  C_FULL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MK1,
        S_MK2,
        S_MH,
        S_MX,
        S_F1,
        S_F2
    } t_state;

    typedef enum logic [1:0] {
        PH_WORD,
        PH_TAIL,
        PH_LEN
    } t_phase;

endpackage

// ----- rtl/m2a_mul.sv -----
module m2a_mul
    import m2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    output logic [31:0] o_p
);

    logic [31:0] r_p;
    logic [31:0] w_prod;

    // low half of a * M, modulo 2^32
    assign w_prod = i_a * C_M;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_prod;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/murmur2a_hash32_top.sv -----
// MurmurHash2A, 32-bit, over a stream of little-endian 32-bit words.
// Input channel: i_in_valid / o_in_ready carry i_data_word, i_bytes_valid and
// i_last. A message is a run of beats closed by a beat with i_last set; only
// that beat's i_bytes_valid (0..4, larger values count as 4) is honored.
// Output channel: o_out_valid / i_out_ready carry o_hash, one beat per message.
// Seed: the user writes it through i_seed_we / i_seed only while idle; the
// block does not enforce it. Loaded at a message's first beat. Reset value is zero.
// Datapath: all arithmetic runs on one registered 32x32 multiplier by M,
// three products per word mix, in states S_MK1, S_MK2, S_MH and S_MX. A
// non-last beat holds o_in_ready low until its mix ends. A last beat runs
// the tail mix, the length mix, S_F1 and S_F2 before o_out_valid rises;
// with 4 valid bytes a word mix comes first. The output register lets the
// next message start while a hash waits; if the receiver still stalls when
// the next hash is ready, the sequencer holds until the pending beat is taken.
// Reset (synchronous, active low) clears the sequencer, message state, seed
// and output valid; the block is ready in the first cycle after reset.
module murmur2a_hash32_top
    import m2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_bytes_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash
);

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [31:0] r_seed;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h, n_h;
    logic [31:0] r_total, n_total;
    logic        r_in_msg, n_in_msg;
    logic        r_last, n_last;
    logic [31:0] r_hash, n_hash;
    logic        r_out_valid, n_out_valid;

    logic        w_mul_en;
    logic [31:0] w_mul_a;
    logic [31:0] w_p;
    logic [2:0]  w_nv;
    logic [31:0] w_mask;
    logic [31:0] w_base_total;
    logic [31:0] w_add;

    m2a_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .o_p   (w_p)
    );

    assign w_nv = (i_bytes_valid > C_FULL_BYTES) ? C_FULL_BYTES : i_bytes_valid;

    always_comb begin
        case (w_nv)
            3'd0:    w_mask = 32'h0000_0000;
            3'd1:    w_mask = 32'h0000_00ff;
            3'd2:    w_mask = 32'h0000_ffff;
            3'd3:    w_mask = 32'h00ff_ffff;
            default: w_mask = 32'hffff_ffff;
        endcase
    end

    assign w_base_total = r_in_msg ? r_total : 32'd0;
    assign w_add        = i_last ? {29'd0, w_nv} : 32'd4;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_k         = r_k;
        n_h         = r_h;
        n_total     = r_total;
        n_in_msg    = r_in_msg;
        n_last      = r_last;
        n_hash      = r_hash;
        n_out_valid = r_out_valid;
        w_mul_en    = 1'b0;
        w_mul_a     = r_k;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_h      = r_in_msg ? r_h : r_seed;
                    n_total  = w_base_total + w_add;
                    n_in_msg = ~i_last;
                    n_last   = i_last;
                    // a last beat short of a full word goes straight to the tail mix
                    if (!i_last || (w_nv == C_FULL_BYTES)) begin
                        n_k     = i_data_word;
                        n_phase = PH_WORD;
                    end else begin
                        n_k     = i_data_word & w_mask;
                        n_phase = PH_TAIL;
                    end
                    n_state = S_MK1;
                end
            end
            S_MK1: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_k;
                n_state  = S_MK2;
            end
            S_MK2: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_p ^ (w_p >> C_R);
                n_state  = S_MH;
            end
            S_MH: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_h;
                n_k      = w_p;
                n_state  = S_MX;
            end
            S_MX: begin
                n_h = w_p ^ r_k;
                case (r_phase)
                    PH_WORD: begin
                        if (r_last) begin
                            n_k     = 32'd0;
                            n_phase = PH_TAIL;
                            n_state = S_MK1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    PH_TAIL: begin
                        n_k     = r_total;
                        n_phase = PH_LEN;
                        n_state = S_MK1;
                    end
                    PH_LEN: begin
                        n_state = S_F1;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_F1: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_h ^ (r_h >> C_FIN_SH1);
                n_state  = S_F2;
            end
            S_F2: begin
                // wait here while a previous hash is still stalled
                if (!r_out_valid || i_out_ready) begin
                    n_hash      = w_p ^ (w_p >> C_FIN_SH2);
                    n_h         = n_hash;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_WORD;
            r_seed      <= 32'd0;
            r_h         <= 32'd0;
            r_total     <= 32'd0;
            r_in_msg    <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_h         <= n_h;
            r_total     <= n_total;
            r_in_msg    <= n_in_msg;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_seed_we) begin
                r_seed <= i_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_hash <= n_hash;
    end

    a_beat_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MK1))
        else $error("accepted beat did not start a mix");

    a_non_last_no_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_last) |=> !$rose(o_out_valid))
        else $error("hash raised after a non-last beat");

    a_hash_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_F2))
        else $error("output valid raised outside the final step");

    a_last_ends_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last) |=> !r_in_msg)
        else $error("message still open after last beat");

endmodule
